// ===== hw/rtl/tcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console cell writer package
// Shared sizes, codes and item types for the console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry.
	localparam int SCREEN_CELLS = 2000;
	localparam int ROW_CELLS    = 80;

	// Widths fixed by the item fields and by the geometry.
	localparam int CURSOR_W = 11;
	localparam int INDEX_W  = 11;
	localparam int ADDR_W   = $clog2(SCREEN_CELLS);
	localparam int COL_W    = $clog2(ROW_CELLS);
	localparam int CELL_W   = 16;

	// Command codes.
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_BLANK = 2'd2;

	// Configuration register indexes.
	localparam logic REG_BACK_COLOR = 1'b0;
	localparam logic REG_FORE_COLOR = 1'b1;

	// Reset values of the color registers.
	localparam logic [3:0] BACK_COLOR_RST = 4'd2;
	localparam logic [3:0] FORE_COLOR_RST = 4'd8;

	// Special character codes.
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] ATTR_BLANK   = 8'h0F;

	// One stored cell: character and attribute.
	typedef struct packed {
		logic [7:0] chr;
		logic [7:0] attr;
	} tcw_cell_t;

	localparam tcw_cell_t BLANK_CELL = '{chr: CHAR_SPACE, attr: ATTR_BLANK};

	// Input item.
	typedef struct packed {
		logic [1:0]         cmd;
		logic [7:0]         char_code;
		logic [INDEX_W-1:0] cell_index;
	} tcw_in_t;

	// Result item.
	typedef struct packed {
		logic [CURSOR_W-1:0] cursor;
		logic [7:0]          cell_char;
		logic [7:0]          cell_attr;
	} tcw_out_t;

	// Access request from the sequencer to the cell memory.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		tcw_cell_t         wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} tcw_ram_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tcw_cell_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cell memory
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Console sequencer
// Decodes items, keeps the cursor, drives the cell memory and runs the
// blanking sweeps one cell per cycle.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire tcw_pkg::tcw_in_t      item,
	input  wire logic [7:0]            attr,
	input  wire tcw_pkg::tcw_cell_t    ram_rdata,
	output tcw_pkg::tcw_ram_req_t      ram_req,
	output logic                       busy,
	output logic                       done,
	output tcw_pkg::tcw_out_t          result
);

	import tcw_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BLANK,
		ST_READ
	} state_t;

	localparam logic [CURSOR_W-1:0] SCREEN_END  = CURSOR_W'(SCREEN_CELLS);
	localparam logic [ADDR_W-1:0]   ADDR_LAST   = ADDR_W'(SCREEN_CELLS - 1);
	localparam logic [COL_W-1:0]    COL_LAST    = COL_W'(ROW_CELLS - 1);
	localparam logic [CURSOR_W:0]   ROW_STEP    = (CURSOR_W + 1)'(ROW_CELLS);
	localparam logic [CURSOR_W:0]   SCREEN_WIDE = (CURSOR_W + 1)'(SCREEN_CELLS);

	state_t              state_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   end_q;
	logic                report_q;
	logic                put_pend_q;
	tcw_cell_t           put_cell_q;
	logic [CURSOR_W-1:0] cursor_q;
	logic [COL_W-1:0]    col_q;
	logic                done_q;
	tcw_out_t            result_q;

	logic                accept;
	logic                at_end;
	logic [CURSOR_W:0]   nl_next;
	logic [CURSOR_W-1:0] cursor_inc;
	logic [COL_W-1:0]    col_inc;
	logic                idx_ok;
	tcw_cell_t           new_cell;
	logic                put_char;
	logic                slow_item;
	logic                done_next;

	// Item decode helpers.
	assign accept     = start && (state_q == ST_IDLE);
	assign at_end     = (cursor_q >= SCREEN_END);
	assign nl_next    = {1'b0, cursor_q} - {{(CURSOR_W + 1 - COL_W){1'b0}}, col_q} + ROW_STEP;
	assign cursor_inc = cursor_q + CURSOR_W'(1);
	assign col_inc    = (col_q == COL_LAST) ? '0 : col_q + COL_W'(1);
	assign idx_ok     = (item.cell_index < SCREEN_END);
	assign new_cell   = '{chr: item.char_code, attr: attr};

	// An ordinary byte that is written in place at the cursor.
	assign put_char = (item.cmd == CMD_PUT) && (item.char_code != CHAR_NUL) &&
		(item.char_code != CHAR_NEWLINE) && !at_end;

	// Items that need a sweep or a memory read before their result.
	assign slow_item = ((item.cmd == CMD_PUT) && ((item.char_code == CHAR_NEWLINE) ||
		((item.char_code != CHAR_NUL) && at_end))) ||
		((item.cmd == CMD_READ) && idx_ok) || (item.cmd == CMD_BLANK);

	// The result strobe for the next cycle.
	always_comb begin
		unique case (state_q)
			ST_CLEAR: done_next = (addr_q == ADDR_LAST) && report_q;
			ST_BLANK: done_next = (addr_q == end_q);
			ST_READ:  done_next = 1'b1;
			ST_IDLE:  done_next = accept && !slow_item;
			default:  done_next = 1'b0;
		endcase
	end

	// Memory accesses: sweep writes, a direct put, or a cell read.
	always_comb begin
		ram_req       = '0;
		ram_req.wdata = BLANK_CELL;
		unique case (state_q)
			ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = addr_q;
				if (put_pend_q && addr_q == '0) begin
					ram_req.wdata = put_cell_q;
				end
			end
			ST_BLANK: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = addr_q;
			end
			ST_IDLE: begin
				if (accept && item.cmd == CMD_PUT && item.char_code != CHAR_NUL &&
						item.char_code != CHAR_NEWLINE && !at_end) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = ADDR_W'(cursor_q);
					ram_req.wdata = new_cell;
				end
				if (accept && item.cmd == CMD_READ && idx_ok) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = ADDR_W'(item.cell_index);
				end
			end
			default: begin
			end
		endcase
	end

	// State, cursor and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			end_q      <= '0;
			report_q   <= 1'b0;
			put_pend_q <= 1'b0;
			put_cell_q <= BLANK_CELL;
			cursor_q   <= '0;
			col_q      <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= done_next;
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == ADDR_LAST) begin
						state_q    <= ST_IDLE;
						put_pend_q <= 1'b0;
						report_q   <= 1'b0;
						if (report_q) begin
							result_q <= '{cursor: cursor_q, cell_char: '0, cell_attr: '0};
						end
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				ST_BLANK: begin
					if (addr_q == end_q) begin
						state_q  <= ST_IDLE;
						result_q <= '{cursor: cursor_q, cell_char: '0, cell_attr: '0};
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				ST_READ: begin
					state_q  <= ST_IDLE;
					result_q <= '{cursor: cursor_q, cell_char: ram_rdata.chr,
						cell_attr: ram_rdata.attr};
				end
				ST_IDLE: begin
					if (accept) begin
						// Default: an immediate result with the cursor after the item.
						result_q <= '{cursor: put_char ? cursor_inc : cursor_q,
							cell_char: '0, cell_attr: '0};
						unique case (item.cmd)
							CMD_PUT: begin
								if (item.char_code == CHAR_NUL) begin
									// A null byte changes nothing.
								end else if (item.char_code == CHAR_NEWLINE) begin
									col_q  <= '0;
									if (nl_next >= SCREEN_WIDE) begin
										// Newline off the last row blanks the screen.
										state_q  <= ST_CLEAR;
										addr_q   <= '0;
										report_q <= 1'b1;
										cursor_q <= '0;
									end else begin
										// Blank the rest of the row.
										state_q  <= ST_BLANK;
										addr_q   <= ADDR_W'(cursor_q);
										end_q    <= ADDR_W'(nl_next - (CURSOR_W + 1)'(1));
										cursor_q <= nl_next[CURSOR_W-1:0];
									end
								end else if (at_end) begin
									// Wrap: blank the screen, the sweep puts the byte at cell 0.
									state_q    <= ST_CLEAR;
									addr_q     <= '0;
									report_q   <= 1'b1;
									put_pend_q <= 1'b1;
									put_cell_q <= new_cell;
									cursor_q   <= CURSOR_W'(1);
									col_q      <= COL_W'(1);
								end else begin
									cursor_q <= cursor_inc;
									col_q    <= col_inc;
								end
							end
							CMD_READ: begin
								if (idx_ok) begin
									state_q <= ST_READ;
								end
							end
							CMD_BLANK: begin
								state_q  <= ST_CLEAR;
								addr_q   <= '0;
								report_q <= 1'b1;
								cursor_q <= '0;
								col_q    <= '0;
							end
							default: begin
								// Unused command: report the cursor only.
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== hw/rtl/text_console_cell_writer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text console cell writer
// Character and attribute console engine with a cell memory and a cursor.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item gives one
// result, shown for exactly one cycle with done high, and the receiver cannot
// stall it. After reset the block blanks all 2000 cells of the memory with
// busy high. The result of an ordinary character or an ignored item appears
// in the cycle after it is taken; a cell read passes through the READ state
// for the memory's registered read port. A newline blanks the rest of its row
// at one cell per cycle, and a blank-screen command, a newline off the last
// row, or a character put at the screen end sweeps all 2000 cells, one memory
// write per cycle. Color registers may be written at any time the block is
// idle and take effect on the next character.
// ----------------------------------------------------------------------------
module text_console_cell_writer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire tcw_pkg::tcw_in_t  item,
	output logic                   busy,
	output logic                   done,
	output tcw_pkg::tcw_out_t      result,
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [3:0]        wr_data
);

	import tcw_pkg::*;

	logic [3:0]    back_color_q;
	logic [3:0]    fore_color_q;
	tcw_ram_req_t  ram_req;
	logic [CELL_W-1:0] ram_rdata;

	// Color registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_color_q <= BACK_COLOR_RST;
			fore_color_q <= FORE_COLOR_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BACK_COLOR: back_color_q <= wr_data;
				REG_FORE_COLOR: fore_color_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer.
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.attr      ({back_color_q, fore_color_q}),
		.ram_rdata (tcw_cell_t'(ram_rdata)),
		.ram_req   (ram_req),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	// Cell memory.
	tcw_cell_ram #(
		.DEPTH (SCREEN_CELLS),
		.WIDTH (CELL_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// A result is only ever shown while the sequencer is back at rest.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while busy");

	// The reported cursor never passes the screen end.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.cursor <= CURSOR_W'(SCREEN_CELLS)))
		else $error("cursor beyond screen end");

	// A blank-screen command always starts a sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_BLANK) |=> (busy && !done))
		else $error("blank command did not start a sweep");

	// A read of a valid cell answers once the READ state has passed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_READ &&
			item.cell_index < INDEX_W'(SCREEN_CELLS)) |=> ##1 done)
		else $error("cell read did not answer on time");

endmodule
`default_nettype wire
